>>> hw/rtl/jrc_pkg.sv
// Shared constants and interface types for the journal record checksum block.
`timescale 1ns / 1ps

package jrc_pkg;

    localparam int unsigned CRC_WIDTH  = 32;
    localparam int unsigned BYTE_WIDTH = 8;
    localparam int unsigned BIN_WIDTH  = 32;
    localparam int unsigned DEC_DIGITS = 10;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned DIGIT_IDX_W = $clog2(DEC_DIGITS);
    localparam int unsigned BIT_CNT_W  = $clog2(BIN_WIDTH);

    localparam logic [CRC_WIDTH-1:0]  CRC_POLY    = 32'hEDB8_8320;
    localparam logic [CRC_WIDTH-1:0]  CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [BYTE_WIDTH-1:0] TEXT_LOW    = 8'd32;
    localparam logic [BYTE_WIDTH-1:0] TEXT_HIGH   = 8'd126;
    localparam logic [BYTE_WIDTH-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [BYTE_WIDTH-1:0] ASCII_SPACE = 8'h20;

    typedef logic [DEC_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

    typedef struct packed {
        logic                  init;
        logic                  start;
        logic [BYTE_WIDTH-1:0] data;
    } crc_ctrl_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [CRC_WIDTH-1:0] crc;
    } crc_stat_t;

    typedef struct packed {
        logic                 start;
        logic [BIN_WIDTH-1:0] value;
    } dec_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
        bcd_t bcd;
    } dec_stat_t;

endpackage

>>> hw/rtl/jrc_crc_unit.sv
// Bit-serial reflected CRC-32 engine that folds in one byte at a time, low bit first.
`timescale 1ns / 1ps

module jrc_crc_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  jrc_pkg::crc_ctrl_t ctrl,
    output jrc_pkg::crc_stat_t stat
);

    logic [jrc_pkg::CRC_WIDTH-1:0]  crc_reg, crc_next;
    logic [jrc_pkg::BYTE_WIDTH-1:0] sh_reg, sh_next;
    logic [2:0]                     cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           fb;
    logic [jrc_pkg::CRC_WIDTH-1:0]  crc_shift;

    // The data bit is folded in at the point where it meets the CRC's low bit.
    assign fb        = crc_reg[0] ^ sh_reg[0];
    assign crc_shift = {1'b0, crc_reg[jrc_pkg::CRC_WIDTH-1:1]}
                       ^ (fb ? jrc_pkg::CRC_POLY : '0);

    always_comb begin
        crc_next  = crc_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctrl.init) begin
            crc_next  = jrc_pkg::CRC_INIT;
            busy_next = 1'b0;
        end else if (ctrl.start) begin
            sh_next   = ctrl.data;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            crc_next = crc_shift;
            sh_next  = {1'b0, sh_reg[jrc_pkg::BYTE_WIDTH-1:1]};
            cnt_next = cnt_reg + 3'd1;
            if (&cnt_reg) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg  <= jrc_pkg::CRC_INIT;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            crc_reg  <= crc_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg <= sh_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg & (&cnt_reg);
    assign stat.crc  = crc_reg;

endmodule

>>> hw/rtl/jrc_dec_unit.sv
// Shift-and-add-three binary to decimal converter, one bit per cycle.
`timescale 1ns / 1ps

module jrc_dec_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  jrc_pkg::dec_ctrl_t ctrl,
    output jrc_pkg::dec_stat_t stat
);

    jrc_pkg::bcd_t                   bcd_reg, bcd_next, adj;
    logic [jrc_pkg::BIN_WIDTH-1:0]   bin_reg, bin_next;
    logic [jrc_pkg::BIT_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            last_bit;

    assign last_bit = (cnt_reg == jrc_pkg::BIT_CNT_W'(jrc_pkg::BIN_WIDTH - 1));

    // Each digit that would overflow on doubling is corrected before the shift.
    always_comb begin
        for (int i = 0; i < jrc_pkg::DEC_DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    always_comb begin
        bcd_next  = bcd_reg;
        bin_next  = bin_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctrl.start) begin
            bcd_next  = '0;
            bin_next  = ctrl.value;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // The top digit of a 32-bit value never exceeds four, so its high bit is
            // always clear and drops out of the shift.
            bcd_next  = {adj[jrc_pkg::DEC_DIGITS-1][jrc_pkg::DIGIT_W-2:0],
                         adj[jrc_pkg::DEC_DIGITS-2:0],
                         bin_reg[jrc_pkg::BIN_WIDTH-1]};
            bin_next  = {bin_reg[jrc_pkg::BIN_WIDTH-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
            if (last_bit) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg & last_bit;
    assign stat.bcd  = bcd_reg;

endmodule

>>> hw/rtl/journal_record_crc.sv
// Top level of the journal record checksum: sequencer, counters and result register.
`timescale 1ns / 1ps

// journal_record_crc computes a reflected CRC-32 over a record made of a decimal
// text prefix and a run of payload bytes. Transactions arrive on the s_ channel
// under valid/ready. A header transaction (s_op = 0) restarts the record: the
// session, sequence and job numbers are converted to decimal text, each number
// followed by a space, and that text is folded into a CRC that starts at all ones.
// Payload transactions (s_op = 1) each add one byte. The byte marked s_last
// produces one transaction on the m_ channel: the complemented CRC, the payload
// length (saturating at MAX_PAYLOAD) and a flag that is set when every byte was
// printable and the length lay within 1 to MAX_PAYLOAD.
// Every byte passes through a single bit-serial CRC unit, so the block takes no new
// transaction until the unit has folded in the last byte; a final byte is then
// registered as a result. A header is converted number by number to decimal and
// its digits and spaces are fed to the CRC unit, with leading zeros skipped, before
// the block returns to idle. s_ready is high only while idle.
// The result sits in an output register; a new transaction may be taken while it
// waits. If the receiver stalls, a further final byte holds the block, with s_ready
// low, until the receiver takes the first result.
// Synchronous reset returns the CRC to all ones, clears the count and the output valid flag.
module journal_record_crc #(
    parameter int unsigned MAX_PAYLOAD = 224
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [31:0] s_session,
    input  logic [31:0] s_seq_number,
    input  logic [31:0] s_job_id,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_crc_value,
    output logic [7:0]  m_payload_length,
    output logic        m_text_ok
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_BCD  = 6'b000010,
        ST_PICK = 6'b000100,
        ST_FEED = 6'b001000,
        ST_PAY  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    state_t state_reg, state_next;

    jrc_pkg::crc_ctrl_t crc_ctrl;
    jrc_pkg::crc_stat_t crc_stat;
    jrc_pkg::dec_ctrl_t dec_ctrl;
    jrc_pkg::dec_stat_t dec_stat;

    // Sequencer context for the decimal prefix.
    logic [31:0]                       seq_reg, seq_next;
    logic [31:0]                       job_reg, job_next;
    logic [1:0]                        word_reg, word_next;
    logic [jrc_pkg::DIGIT_IDX_W-1:0]   idx_reg, idx_next;
    logic                              started_reg, started_next;
    logic                              space_reg, space_next;

    // Record counters and the pending end-of-record mark.
    logic [7:0] count_reg, count_next;
    logic       flag_reg, flag_next;
    logic       last_reg, last_next;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_crc_reg, out_crc_next;
    logic [7:0]  out_len_reg, out_len_next;
    logic        out_ok_reg, out_ok_next;

    logic       s_fire;
    logic       byte_printable;
    logic [3:0] cur_digit;

    assign s_ready        = (state_reg == ST_IDLE);
    assign s_fire         = s_valid & s_ready;
    assign byte_printable = (s_data_byte >= jrc_pkg::TEXT_LOW)
                            && (s_data_byte <= jrc_pkg::TEXT_HIGH);
    assign cur_digit      = dec_stat.bcd[idx_reg];

    always_comb begin
        state_next     = state_reg;
        seq_next       = seq_reg;
        job_next       = job_reg;
        word_next      = word_reg;
        idx_next       = idx_reg;
        started_next   = started_reg;
        space_next     = space_reg;
        count_next     = count_reg;
        flag_next      = flag_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_crc_next   = out_crc_reg;
        out_len_next   = out_len_reg;
        out_ok_next    = out_ok_reg;

        crc_ctrl.init  = 1'b0;
        crc_ctrl.start = 1'b0;
        crc_ctrl.data  = s_data_byte;
        dec_ctrl.start = 1'b0;
        dec_ctrl.value = s_session;

        // The receiver taking the held result frees the output register.
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (!s_op) begin
                        // A header abandons any open record and begins a new one.
                        crc_ctrl.init  = 1'b1;
                        dec_ctrl.start = 1'b1;
                        dec_ctrl.value = s_session;
                        seq_next       = s_seq_number;
                        job_next       = s_job_id;
                        word_next      = 2'd0;
                        count_next     = '0;
                        flag_next      = 1'b1;
                        state_next     = ST_BCD;
                    end else begin
                        crc_ctrl.start = 1'b1;
                        crc_ctrl.data  = s_data_byte;
                        last_next      = s_last;
                        flag_next      = flag_reg & byte_printable & (count_reg < MAX_LEN);
                        count_next     = (count_reg >= MAX_LEN) ? MAX_LEN : count_reg + 8'd1;
                        state_next     = ST_PAY;
                    end
                end
            end
            ST_BCD: begin
                if (dec_stat.done) begin
                    idx_next     = jrc_pkg::DIGIT_IDX_W'(jrc_pkg::DEC_DIGITS - 1);
                    started_next = 1'b0;
                    space_next   = 1'b0;
                    state_next   = ST_PICK;
                end
            end
            ST_PICK: begin
                if (space_reg) begin
                    crc_ctrl.start = 1'b1;
                    crc_ctrl.data  = jrc_pkg::ASCII_SPACE;
                    state_next     = ST_FEED;
                end else if (!started_reg && (cur_digit == 4'd0) && (idx_reg != '0)) begin
                    // Leading zero: skipped, but a lone zero is still sent.
                    idx_next = idx_reg - 1'b1;
                end else begin
                    crc_ctrl.start = 1'b1;
                    crc_ctrl.data  = jrc_pkg::ASCII_ZERO | {4'd0, cur_digit};
                    started_next   = 1'b1;
                    state_next     = ST_FEED;
                end
            end
            ST_FEED: begin
                if (crc_stat.done) begin
                    if (space_reg) begin
                        if (word_reg == 2'd2) begin
                            state_next = ST_IDLE;
                        end else begin
                            word_next      = word_reg + 2'd1;
                            dec_ctrl.start = 1'b1;
                            dec_ctrl.value = (word_reg == 2'd0) ? seq_reg : job_reg;
                            state_next     = ST_BCD;
                        end
                    end else begin
                        if (idx_reg == '0) begin
                            space_next = 1'b1;
                        end else begin
                            idx_next = idx_reg - 1'b1;
                        end
                        state_next = ST_PICK;
                    end
                end
            end
            ST_PAY: begin
                if (crc_stat.done) begin
                    state_next = last_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT: begin
                // Wait here only while an earlier result is still unclaimed.
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_crc_next   = ~crc_stat.crc;
                    out_len_next   = count_reg;
                    out_ok_next    = flag_reg && (count_reg != 8'd0) && (count_reg <= MAX_LEN);
                    crc_ctrl.init  = 1'b1;
                    count_next     = '0;
                    flag_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            word_reg      <= '0;
            idx_reg       <= '0;
            started_reg   <= 1'b0;
            space_reg     <= 1'b0;
            count_reg     <= '0;
            flag_reg      <= 1'b1;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            idx_reg       <= idx_next;
            started_reg   <= started_next;
            space_reg     <= space_next;
            count_reg     <= count_next;
            flag_reg      <= flag_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        seq_reg     <= seq_next;
        job_reg     <= job_next;
        out_crc_reg <= out_crc_next;
        out_len_reg <= out_len_next;
        out_ok_reg  <= out_ok_next;
    end

    jrc_crc_unit u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (crc_ctrl),
        .stat    (crc_stat)
    );

    jrc_dec_unit u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (dec_ctrl),
        .stat    (dec_stat)
    );

    assign m_valid          = out_valid_reg;
    assign m_crc_value      = out_crc_reg;
    assign m_payload_length = out_len_reg;
    assign m_text_ok        = out_ok_reg;

`ifndef SYNTHESIS
    // A new byte must never be loaded into the CRC unit while it is still shifting.
    a_crc_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        crc_ctrl.start |-> !crc_stat.busy)
        else $error("CRC unit started while busy");

    // The converter only finishes while the sequencer waits for it.
    a_dec_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        dec_stat.done |-> (state_reg == ST_BCD))
        else $error("decimal conversion finished outside its wait state");

    // A result flagged as valid text always carries a length within range.
    a_ok_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_text_ok) |-> ((m_payload_length != 8'd0)
                                    && (m_payload_length <= MAX_LEN)))
        else $error("text flag set with an out-of-range length");

    // The block is never ready for input while a byte is still in the CRC unit or a conversion is running.
    a_ready_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!crc_stat.busy && !dec_stat.busy))
        else $error("input accepted while a unit is busy");
`endif

endmodule
